FILE: src/atrim_pkg.sv
// Shared constants, types and register codes for the adapter suffix trim unit.
`default_nettype none

package atrim_pkg;

	localparam int MAX_ADAPTER = 32;
	localparam int LENGTH_BITS = 16;
	localparam int CHAR_W      = 8;
	localparam int ADP_LEN_W   = $clog2(MAX_ADAPTER + 1);
	localparam int CHARS_REGS  = 4;
	localparam int CHARS_PER_REG = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;

	localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

	typedef logic [CHAR_W-1:0] char_t;
	typedef char_t [MAX_ADAPTER-1:0] window_t;
	typedef char_t [CHARS_REGS*CHARS_PER_REG-1:0] adapter_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_READ_LENGTH    = 3'd0,
		CFG_ADAPTER_LENGTH = 3'd1,
		CFG_ADAPTER_CHARS0 = 3'd2,
		CFG_ADAPTER_CHARS1 = 3'd3,
		CFG_ADAPTER_CHARS2 = 3'd4,
		CFG_ADAPTER_CHARS3 = 3'd5
	} cfg_idx_t;

	// Status of the window stage toward the result stage
	typedef struct packed {
		logic                   pend;
		logic [LENGTH_BITS-1:0] count;
	} win_stat_t;

endpackage

`default_nettype wire

FILE: src/atrim_window.sv
// Tail window of recent characters and saturating read length counter.
`default_nettype none

module atrim_window
	import atrim_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire char_t     base,
	input  wire logic      last_base,
	input  wire logic      take,
	output window_t        win,
	output win_stat_t      stat
);

	window_t                win_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic                   last_q;
	logic                   pend_q;

	window_t                win_base;
	window_t                win_d;
	logic [LENGTH_BITS-1:0] count_base;
	logic [LENGTH_BITS-1:0] count_d;

	// Start from an empty window and zero count after a finished read
	always_comb begin
		win_base   = last_q ? '0 : win_q;
		count_base = last_q ? '0 : count_q;
		win_d[0]   = base;
		for (int k = 1; k < MAX_ADAPTER; k++) begin
			win_d[k] = win_base[k-1];
		end
		count_d = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 1'b1;
	end

	// Advance window and count on each accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q   <= win_d;
			count_q <= count_d;
		end
	end

	// Track end of read and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b1;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				last_q <= last_base;
				pend_q <= last_base;
			end else if (take) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign win        = win_q;
	assign stat.pend  = pend_q;
	assign stat.count = count_q;

endmodule

`default_nettype wire

FILE: src/atrim_overlap.sv
// Parallel suffix/prefix overlap search between the window and the adapter.
`default_nettype none

module atrim_overlap
	import atrim_pkg::*;
(
	input  wire window_t                win,
	input  wire adapter_t               adapter,
	input  wire logic [ADP_LEN_W-1:0]   adapter_length,
	input  wire logic [LENGTH_BITS-1:0] read_length,
	input  wire logic [LENGTH_BITS-1:0] count,
	output logic [ADP_LEN_W-1:0]        trim,
	output logic                        qualified
);

	logic [MAX_ADAPTER:1]   hit;
	logic [ADP_LEN_W-1:0]   lim_a;
	logic [ADP_LEN_W-1:0]   lim;
	logic [ADP_LEN_W-1:0]   best;

	// Compare every overlap length at once
	always_comb begin
		for (int i = 1; i <= MAX_ADAPTER; i++) begin
			hit[i] = 1'b1;
			for (int j = 0; j < i; j++) begin
				if (win[i-1-j] != adapter[j]) begin
					hit[i] = 1'b0;
				end
			end
		end
	end

	// Clip the overlap to the adapter size and the read length, keep the longest; zero unless the length qualifies
	always_comb begin
		lim_a = (adapter_length > ADP_LEN_W'(MAX_ADAPTER)) ?
			ADP_LEN_W'(MAX_ADAPTER) : adapter_length;
		if ({{(LENGTH_BITS-ADP_LEN_W){1'b0}}, lim_a} > count) begin
			lim = count[ADP_LEN_W-1:0];
		end else begin
			lim = lim_a;
		end
		best = '0;
		for (int i = 1; i <= MAX_ADAPTER; i++) begin
			if (hit[i] && (ADP_LEN_W'(i) <= lim)) begin
				best = ADP_LEN_W'(i);
			end
		end
		qualified = (count == read_length);
		trim      = qualified ? best : '0;
	end

endmodule

`default_nettype wire

FILE: src/adapter_suffix_trim_unit.sv
// Top level of the adapter suffix trim unit: configuration, window, overlap and result register.
// The unit takes one read character per clock. It stalls its input only while a finished
// result waits in the window stage behind a stalled, full output register, and holds it for
// as long as the output stays stalled in that state. For a word marked as the last character
// of a read, the edge that takes that character shifts the window and marks the result
// pending; the result word (trim length, counted length, qualified flag) is then loaded into
// the output register from the 32-way parallel overlap compare once that register is free.
// Reads with other lengths still report their length, with a zero trim. Configuration writes
// are always ready and take effect at once; change them only while no read is in flight.
`default_nettype none

module adapter_suffix_trim_unit
	import atrim_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [CHAR_W-1:0]      base,
	input  wire logic                   last_base,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [ADP_LEN_W-1:0]        trim_count,
	output logic [LENGTH_BITS-1:0]      seen_length,
	output logic                        length_qualified,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [LENGTH_BITS-1:0] read_length_q;
	logic [ADP_LEN_W-1:0]   adapter_length_q;
	logic [CFG_DATA_W-1:0]  chars_q [CHARS_REGS];
	adapter_t               adapter;

	window_t                win;
	win_stat_t              stat;
	logic                   accept;
	logic                   take;
	logic [ADP_LEN_W-1:0]   trim;
	logic                   qualified;

	logic                   out_valid_q;
	logic [ADP_LEN_W-1:0]   trim_q;
	logic [LENGTH_BITS-1:0] seen_q;
	logic                   qual_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_length_q    <= LENGTH_BITS'(150);
			adapter_length_q <= '0;
			for (int r = 0; r < CHARS_REGS; r++) begin
				chars_q[r] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_READ_LENGTH:    read_length_q    <= cfg_data[LENGTH_BITS-1:0];
				CFG_ADAPTER_LENGTH: adapter_length_q <= cfg_data[ADP_LEN_W-1:0];
				CFG_ADAPTER_CHARS0: chars_q[0]       <= cfg_data;
				CFG_ADAPTER_CHARS1: chars_q[1]       <= cfg_data;
				CFG_ADAPTER_CHARS2: chars_q[2]       <= cfg_data;
				CFG_ADAPTER_CHARS3: chars_q[3]       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack adapter characters, lowest byte first
	always_comb begin
		for (int c = 0; c < CHARS_REGS*CHARS_PER_REG; c++) begin
			adapter[c] = chars_q[c / CHARS_PER_REG][(c % CHARS_PER_REG)*CHAR_W +: CHAR_W];
		end
	end

	// Handshake: hold input only while a result is blocked behind a full output
	assign take     = stat.pend && (!out_valid_q || !out_stall);
	assign in_stall = stat.pend && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	atrim_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.base      (base),
		.last_base (last_base),
		.take      (take),
		.win       (win),
		.stat      (stat)
	);

	atrim_overlap u_overlap (
		.win            (win),
		.adapter        (adapter),
		.adapter_length (adapter_length_q),
		.read_length    (read_length_q),
		.count          (stat.count),
		.trim           (trim),
		.qualified      (qualified)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (take) begin
			trim_q <= trim;
			seen_q <= stat.count;
			qual_q <= qualified;
		end
	end

	assign out_valid        = out_valid_q;
	assign trim_count       = trim_q;
	assign seen_length      = seen_q;
	assign length_qualified = qual_q;

endmodule

`default_nettype wire

FILE: src/atrim_checker.sv
// Port-level checker for the adapter suffix trim unit and its bind.
`default_nettype none

module atrim_checker
	import atrim_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_stall,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire logic [ADP_LEN_W-1:0]   trim_count,
	input  wire logic [LENGTH_BITS-1:0] seen_length,
	input  wire logic                   length_qualified
);

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(trim_count) &&
			$stable(seen_length) && $stable(length_qualified))
		else $error("result word changed while stalled");

	// Unqualified read never trims
	a_unqual_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !length_qualified |-> trim_count == '0)
		else $error("trim on read of wrong length");

	// Trim never exceeds the adapter window
	a_trim_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> trim_count <= ADP_LEN_W'(MAX_ADAPTER))
		else $error("trim beyond window size");

	// Trim never exceeds the read
	a_trim_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {{(LENGTH_BITS-ADP_LEN_W){1'b0}}, trim_count} <= seen_length)
		else $error("trim longer than read");

	// Input stalls only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

endmodule

bind adapter_suffix_trim_unit atrim_checker u_atrim_checker (.*);

`default_nettype wire

FILE: bench/adapter_suffix_trim_unit_test.sv
// Self-checking testbench for the adapter suffix trim unit with a built-in trim predictor.
module adapter_suffix_trim_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import atrim_pkg::*;

	// Indexes that name no register; writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam int RAND_ITEMS = 1850;
	localparam int SETTLE_CYCLES = 6;

	typedef enum {ADP_NUC, ADP_BYTES, ADP_ONES, ADP_ZEROS} adp_fill_t;

	typedef struct packed {
		char_t ch;
		logic  is_last;
	} read_word_t;

	typedef struct packed {
		logic [ADP_LEN_W-1:0]   trim;
		logic [LENGTH_BITS-1:0] len;
		logic                   qual;
	} trim_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [CHAR_W-1:0]      base = '0;
	logic                   last_base = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [ADP_LEN_W-1:0]   trim_count;
	logic [LENGTH_BITS-1:0] seen_length;
	logic                   length_qualified;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Predictor copy of the registers, at their reset values
	logic [LENGTH_BITS-1:0] cfg_read_len = 16'd150;
	logic [ADP_LEN_W-1:0]   cfg_adp_len = '0;
	adapter_t               cfg_adp = '0;

	// Predictor copy of the window and the running length
	window_t                tail = '0;
	logic [LENGTH_BITS-1:0] run_len = '0;

	// Adapter of the current setting, used to build read tails
	adapter_t               gen_adp = '0;

	read_word_t   pending_bases[$];
	trim_result_t expected_trims[$];

	bit word_taken = 1'b0;
	bit drain_hold = 1'b0;
	int gap_left = 0;
	int burst_left = 1;
	int stall_left = 0;
	int stall_mode = 0;
	int error_count = 0;

	adapter_suffix_trim_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.base             (base),
		.last_base        (last_base),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.trim_count       (trim_count),
		.seen_length      (seen_length),
		.length_qualified (length_qualified),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	// Shift one character into the window; at the end of a read, predict the trim
	function automatic void absorb_base(char_t ch, logic is_last);
		trim_result_t res;
		int lim;
		int best;
		bit same;
		tail = {tail[MAX_ADAPTER-2:0], ch};
		if (run_len != COUNT_MAX)
			run_len = run_len + 1'b1;
		if (is_last) begin
			best = 0;
			res.qual = (run_len == cfg_read_len);
			if (res.qual) begin
				lim = (cfg_adp_len > MAX_ADAPTER) ? MAX_ADAPTER : int'(cfg_adp_len);
				if (lim > int'(run_len))
					lim = int'(run_len);
				// Longest read suffix that equals an adapter prefix
				for (int i = 1; i <= lim; i++) begin
					same = 1'b1;
					for (int j = 0; j < i; j++)
						if (tail[i-1-j] != cfg_adp[j])
							same = 1'b0;
					if (same)
						best = i;
				end
			end
			res.trim = ADP_LEN_W'(best);
			res.len = run_len;
			expected_trims.push_back(res);
			tail = '0;
			run_len = '0;
		end
	endfunction

	function automatic char_t nuc_char();
		case ($urandom_range(0, 3))
			0: return "A";
			1: return "C";
			2: return "G";
			default: return "T";
		endcase
	endfunction

	// Mostly nucleotides, now and then any byte
	function automatic char_t read_char();
		if ($urandom_range(0, 3) == 0)
			return char_t'($urandom_range(0, 255));
		return nuc_char();
	endfunction

	// Queue one read whose last tail_m characters are the adapter's first ones
	task automatic queue_read(input int len, input int tail_m, input bit mutate);
		read_word_t w;
		int pos;
		for (int p = 0; p < len; p++) begin
			w.ch = (p >= len - tail_m) ? gen_adp[p - (len - tail_m)] : read_char();
			w.is_last = (p == len - 1);
			pending_bases.push_back(w);
		end
		if (mutate && tail_m > 0) begin
			pos = pending_bases.size() - 1 - $urandom_range(0, tail_m - 1);
			pending_bases[pos].ch = char_t'($urandom_range(0, 255));
		end
	endtask

	// Wait until all words are taken and all results are in, then let the pipe empty
	task automatic settle();
		do
			@(posedge clk);
		while (pending_bases.size() != 0 || in_valid || expected_trims.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write every register, then the two unused indexes
	task automatic load_settings(input int rl, input int al, input adp_fill_t fill);
		logic [CFG_IDX_W-1:0]  idx [8];
		logic [CFG_DATA_W-1:0] val [8];
		for (int j = 0; j < MAX_ADAPTER; j++) begin
			case (fill)
				ADP_NUC:   gen_adp[j] = nuc_char();
				ADP_BYTES: gen_adp[j] = char_t'($urandom_range(0, 255));
				ADP_ONES:  gen_adp[j] = '1;
				default:   gen_adp[j] = '0;
			endcase
		end
		idx[0] = CFG_READ_LENGTH;
		idx[1] = CFG_ADAPTER_LENGTH;
		idx[2] = CFG_ADAPTER_CHARS0;
		idx[3] = CFG_ADAPTER_CHARS1;
		idx[4] = CFG_ADAPTER_CHARS2;
		idx[5] = CFG_ADAPTER_CHARS3;
		idx[6] = CFG_SPARE_A;
		idx[7] = CFG_SPARE_B;
		for (int k = 0; k < 8; k++)
			val[k] = {$urandom, $urandom};
		val[0][LENGTH_BITS-1:0] = LENGTH_BITS'(rl);
		val[1][ADP_LEN_W-1:0] = ADP_LEN_W'(al);
		for (int k = 0; k < CHARS_REGS; k++)
			val[2+k] = gen_adp[k*CHARS_PER_REG +: CHARS_PER_REG];
		for (int k = 0; k < 8; k++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[k])
				CFG_READ_LENGTH:    cfg_read_len = val[k][LENGTH_BITS-1:0];
				CFG_ADAPTER_LENGTH: cfg_adp_len = val[k][ADP_LEN_W-1:0];
				CFG_ADAPTER_CHARS0: cfg_adp[7:0] = val[k];
				CFG_ADAPTER_CHARS1: cfg_adp[15:8] = val[k];
				CFG_ADAPTER_CHARS2: cfg_adp[23:16] = val[k];
				CFG_ADAPTER_CHARS3: cfg_adp[31:24] = val[k];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Check each result word, then predict from each taken input word
	always @(posedge clk) begin : monitor
		trim_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_trims.size() == 0) begin
					$display("%0t: unexpected result trim=%0d length=%0d qualified=%0b",
						$time, trim_count, seen_length, length_qualified);
					error_count++;
				end else begin
					want = expected_trims.pop_front();
					if (trim_count !== want.trim) begin
						$display("%0t: trim_count expected %0d got %0d",
							$time, want.trim, trim_count);
						error_count++;
					end
					if (seen_length !== want.len) begin
						$display("%0t: seen_length expected %0d got %0d",
							$time, want.len, seen_length);
						error_count++;
					end
					if (length_qualified !== want.qual) begin
						$display("%0t: length_qualified expected %0b got %0b",
							$time, want.qual, length_qualified);
						error_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				absorb_base(base, last_base);
				word_taken = 1'b1;
			end
		end
	end

	// Send words in bursts; hold after some read ends until all results are back
	always @(negedge clk) begin : driver
		read_word_t w;
		if (arst_n && (!in_valid || word_taken)) begin
			word_taken = 1'b0;
			if (drain_hold && expected_trims.size() != 0) begin
				in_valid <= 1'b0;
			end else begin
				drain_hold = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bases.size() != 0) begin
					w = pending_bases.pop_front();
					base <= w.ch;
					last_base <= w.is_last;
					in_valid <= 1'b1;
					if (w.is_last && $urandom_range(0, 19) == 0)
						drain_hold = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side: free runs, random stalls, or short solid stalls
	always @(negedge clk) begin : receiver
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = (stall_mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 40);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= 1'b1;
		endcase
	end

	initial begin : stimulus
		int rand_items;
		int rl;
		int al;
		int eff;
		int len;
		int m;
		int kind;
		int sel;
		adp_fill_t fill;
		rand_items = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: lengths never qualify, extreme characters
		pending_bases.push_back(read_word_t'{8'h00, 1'b1});
		pending_bases.push_back(read_word_t'{8'hFF, 1'b0});
		pending_bases.push_back(read_word_t'{8'h00, 1'b0});
		pending_bases.push_back(read_word_t'{8'hFF, 1'b1});
		settle();

		// Shortest read length with the full adapter: overlap limited to one character
		load_settings(1, MAX_ADAPTER, ADP_NUC);
		queue_read(1, 1, 1'b0);
		pending_bases.push_back(read_word_t'{8'hFF, 1'b1});
		queue_read(2, 0, 1'b0);
		settle();

		// Adapter length above the maximum, read shorter than the adapter
		load_settings(6, 63, ADP_NUC);
		queue_read(6, 6, 1'b0);
		queue_read(6, 3, 1'b0);
		settle();

		// Random settings, mostly qualified reads ending in part of the adapter
		while (rand_items < RAND_ITEMS) begin
			sel = $urandom_range(0, 9);
			rl = (sel == 0) ? 1 : (sel == 1) ? $urandom_range(41, 100) : $urandom_range(2, 40);
			sel = $urandom_range(0, 9);
			al = (sel == 0) ? 0 : (sel == 1) ? MAX_ADAPTER : (sel == 2) ? $urandom_range(33, 63)
				: $urandom_range(1, 31);
			sel = $urandom_range(0, 9);
			fill = (sel < 6) ? ADP_NUC : (sel < 8) ? ADP_BYTES : (sel == 8) ? ADP_ONES : ADP_ZEROS;
			load_settings(rl, al, fill);
			eff = (al > MAX_ADAPTER) ? MAX_ADAPTER : al;
			repeat ($urandom_range(4, 14)) begin
				kind = $urandom_range(0, 9);
				len = rl;
				if (kind == 7) begin
					if (rl > 3 && $urandom_range(0, 1) == 1)
						len = rl - $urandom_range(1, 3);
					else
						len = rl + $urandom_range(1, 3);
				end else if (kind == 8) begin
					len = $urandom_range(1, 60);
				end
				m = (kind == 9) ? 0 : $urandom_range(0, (len < eff) ? len : eff);
				queue_read(len, m, kind == 5 || kind == 6);
				rand_items += len;
			end
			settle();
		end

		if (error_count == 0 && expected_trims.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// End a run that hangs
	initial begin : watchdog
		#25_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
